>>> hdl/sfpsc_pkg.sv
// ============================================================================
// sfpsc_pkg
// shared types and constants for the serial frame parser with sum check
// ============================================================================
package sfpsc_pkg;

    // frame layout
    localparam int unsigned HeaderLen = 6;
    localparam logic [8:0] PosVersion = 9'd6;
    localparam logic [8:0] PosType    = 9'd7;
    localparam logic [8:0] PosLength  = 9'd8;
    localparam logic [8:0] PosPayload = 9'd9;

    // configuration register indexes
    localparam logic [1:0] CFG_VERSION = 2'd0;
    localparam logic [1:0] CFG_RPC     = 2'd1;
    localparam logic [1:0] CFG_GAP     = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0]  VersionReset = 8'd1;
    localparam logic [7:0]  RpcReset     = 8'd3;
    localparam logic [15:0] GapReset     = 16'd50;

    // request commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_PROGRESS = 3'd0;
    localparam status_t ST_REJECT   = 3'd1;
    localparam status_t ST_RPC_OK   = 3'd2;
    localparam status_t ST_FRAME_OK = 3'd3;
    localparam status_t ST_SUM_ERR  = 3'd4;

    // expected header byte at a given header position
    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h49; // I
            3'd1:    val = 8'h4D; // M
            3'd2:    val = 8'h50; // P
            3'd3:    val = 8'h52; // R
            3'd4:    val = 8'h4F; // O
            3'd5:    val = 8'h56; // V
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

>>> hdl/serial_frame_parser_sum_check_top.sv
// ============================================================================
// serial_frame_parser_sum_check_top
// frame parser for a serial byte stream with header, version and sum check
// ============================================================================
// usage
//   input channel: in_valid / in_stall with command and data_byte. command
//   low carries a received byte, command high is one time tick.
//   output channel: out_valid / out_stall, one result per request with
//   status, payload_valid, payload_byte, frame_type, frame_len and last.
//   config port: cfg_we, cfg_index, cfg_data; index 0 version byte,
//   1 rpc type, 2 gap ticks; other indexes are ignored. write only while idle.
// timing
//   a request is registered in the input register on acceptance and is
//   evaluated from there once the output register is free or draining; its
//   result is then registered in the output register, which drives out_valid.
//   one request per cycle is sustained while out_stall is low; the parser state
//   (position, running sum, idle counter) is written back as each request advances.
// stall
//   while out_stall holds a result, the next request waits in the input
//   register; in_stall rises only when that register is also full.
// reset
//   rst_n clears both stages and the parser state, and loads the config
//   registers with version 1, rpc type 3, gap 50.
// ============================================================================
module serial_frame_parser_sum_check_top
    import sfpsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  data_byte,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [7:0]  frame_type,
    output logic [7:0]  frame_len,
    output logic        last,
    // config port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // config registers
    logic [7:0]  version_reg;
    logic [7:0]  rpc_reg;
    logic [15:0] gap_reg;

    // input stage
    logic        in_valid_reg;
    logic        command_reg;
    logic [7:0]  data_reg;

    // parser state
    logic [8:0]  pos_reg,  pos_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  len_reg,  len_next;
    logic [7:0]  sum_reg,  sum_next;
    logic [15:0] idle_reg, idle_next;

    // output stage
    logic        out_valid_reg;
    status_t     status_reg,  status_next;
    logic        pvalid_reg,  pvalid_next;
    logic [7:0]  pbyte_reg,   pbyte_next;
    logic [7:0]  otype_reg,   otype_next;
    logic [7:0]  olen_reg,    olen_next;
    logic        last_reg,    last_next;

    logic        advance;
    logic        in_accept;
    logic [16:0] idle_inc;
    logic [8:0]  end_pos;
    logic        reject;
    logic        done;

    // the input stage moves on when the output register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= VersionReset;
            rpc_reg     <= RpcReset;
            gap_reg     <= GapReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VERSION: version_reg <= cfg_data[7:0];
                CFG_RPC:     rpc_reg     <= cfg_data[7:0];
                CFG_GAP:     gap_reg     <= cfg_data;
                default:     ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            command_reg <= command;
            data_reg    <= data_byte;
        end
    end

    // frame end position, valid once the length byte is stored
    assign end_pos  = PosPayload + {1'b0, len_reg};
    assign idle_inc = {1'b0, idle_reg} + 17'd1;

    // one request through the parser
    always_comb
    begin
        pos_next    = pos_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        idle_next   = idle_reg;
        status_next = ST_PROGRESS;
        pvalid_next = 1'b0;
        pbyte_next  = 8'd0;
        last_next   = 1'b0;
        otype_next  = type_reg;
        olen_next   = len_reg;
        reject      = 1'b0;
        done        = 1'b0;

        if (command_reg == CMD_TICK)
        begin
            if (idle_inc > {1'b0, gap_reg})
            begin
                // gap expired: drop any partial frame
                pos_next    = 9'd0;
                type_next   = 8'd0;
                len_next    = 8'd0;
                sum_next    = 8'd0;
                idle_next   = 16'd0;
                status_next = ST_REJECT;
            end
            else
            begin
                idle_next = idle_inc[15:0];
            end
            otype_next = type_next;
            olen_next  = len_next;
        end
        else
        begin
            if (pos_reg < PosVersion)
            begin
                reject = (data_reg != header_byte(pos_reg[2:0]));
            end
            else if (pos_reg == PosVersion)
            begin
                reject = (data_reg != version_reg);
            end
            else if (pos_reg == PosType)
            begin
                type_next = data_reg;
            end
            else if (pos_reg == PosLength)
            begin
                len_next = data_reg;
            end
            else if (pos_reg < end_pos)
            begin
                pvalid_next = 1'b1;
                pbyte_next  = data_reg;
            end
            else
            begin
                // checksum byte
                done      = 1'b1;
                last_next = 1'b1;
                if (data_reg != sum_reg)
                begin
                    status_next = ST_SUM_ERR;
                end
                else if (type_reg == rpc_reg)
                begin
                    status_next = ST_RPC_OK;
                end
                else
                begin
                    status_next = ST_FRAME_OK;
                end
            end

            // result shows the stores before any clear
            otype_next = type_next;
            olen_next  = len_next;

            if (reject || done)
            begin
                pos_next  = 9'd0;
                type_next = 8'd0;
                len_next  = 8'd0;
                sum_next  = 8'd0;
                if (reject)
                begin
                    status_next = ST_REJECT;
                end
                else if (status_next != ST_SUM_ERR)
                begin
                    idle_next = 16'd0;
                end
            end
            else
            begin
                sum_next  = sum_reg + data_reg;
                pos_next  = pos_reg + 9'd1;
                idle_next = 16'd0;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 9'd0;
            type_reg <= 8'd0;
            len_reg  <= 8'd0;
            sum_reg  <= 8'd0;
            idle_reg <= 16'd0;
        end
        else if (advance)
        begin
            pos_reg  <= pos_next;
            type_reg <= type_next;
            len_reg  <= len_next;
            sum_reg  <= sum_next;
            idle_reg <= idle_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            pvalid_reg <= pvalid_next;
            pbyte_reg  <= pbyte_next;
            otype_reg  <= otype_next;
            olen_reg   <= olen_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign payload_valid = pvalid_reg;
    assign payload_byte  = pbyte_reg;
    assign frame_type    = otype_reg;
    assign frame_len     = olen_reg;
    assign last          = last_reg;

endmodule

>>> hdl/sfpsc_checker.sv
// ============================================================================
// sfpsc_checker
// port-level checks for the serial frame parser
// ============================================================================
module sfpsc_checker
    import sfpsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic        payload_valid,
    input logic        last
);

    // a held result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_PROGRESS || status == ST_REJECT ||
                       status == ST_RPC_OK || status == ST_FRAME_OK ||
                       status == ST_SUM_ERR))
        else $error("undefined status code");

    // payload bytes are always plain progress
    a_payload_progress: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> status == ST_PROGRESS && !last)
        else $error("payload byte with end or error status");

    // the frame end carries a verdict
    a_last_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |->
            (status == ST_RPC_OK || status == ST_FRAME_OK || status == ST_SUM_ERR))
        else $error("frame end without verdict");

    // a verdict only comes with the frame end
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_RPC_OK || status == ST_FRAME_OK ||
                      status == ST_SUM_ERR) |-> last && !payload_valid)
        else $error("verdict away from frame end");

endmodule

bind serial_frame_parser_sum_check_top sfpsc_checker u_sfpsc_checker (.*);

>>> tb/tb_top.sv
// ============================================================================
// tb_top
// self-checking testbench for the serial frame parser with sum check
// ============================================================================
// Requests (received bytes and time ticks) go in through the valid/stall
// channel. Each accepted request also runs through a cycle-free model of the
// parser held here, and the model's result is queued. Every result taken
// from the output channel is checked field by field against the oldest
// queued one. Named tests cover good frames, header and version rejects,
// checksum errors, the idle gap and the config registers. A long random run
// follows over several config settings. Both channels idle and stall at
// random, with stretches at full rate.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfpsc_pkg::*;

    // config index that maps to no register
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // frame header, first byte in the top bits
    localparam logic [47:0] HEADER_TEXT = "IMPROV";

    typedef struct packed {
        status_t    status;
        logic       pvalid;
        logic [7:0] pbyte;
        logic [7:0] ftype;
        logic [7:0] flen;
        logic       last;
    } parse_result_t;

    // ------------------------------------------------------------------------
    // clock, reset and block signals
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = CMD_BYTE;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [7:0]  frame_len;
    logic        frame_last;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_VERSION;
    logic [15:0] cfg_data = 16'd0;

    serial_frame_parser_sum_check_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .payload_valid(payload_valid),
        .payload_byte (payload_byte),
        .frame_type   (frame_type),
        .frame_len    (frame_len),
        .last         (frame_last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // parser model: config copy and frame state
    // ------------------------------------------------------------------------
    logic [7:0]  version_cfg = VersionReset;
    logic [7:0]  rpc_cfg = RpcReset;
    logic [15:0] gap_cfg = GapReset;

    logic [8:0]  frame_pos = 9'd0;
    logic [7:0]  type_seen = 8'd0;
    logic [7:0]  len_seen = 8'd0;
    logic [7:0]  byte_sum = 8'd0;
    logic [15:0] idle_ticks = 16'd0;

    parse_result_t expected_results[$];

    int unsigned requests_sent = 0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned good_frames = 0;
    int unsigned sum_errors = 0;
    int unsigned rejects = 0;
    int unsigned payload_seen = 0;
    int unsigned ticks_sent = 0;

    // when set, neither side inserts idle cycles
    bit back_to_back = 1'b0;

    function automatic logic [7:0] header_at(input int idx);
        return HEADER_TEXT[8 * (5 - idx) +: 8];
    endfunction

    function automatic void drop_frame();
        frame_pos = 9'd0;
        type_seen = 8'd0;
        len_seen = 8'd0;
        byte_sum = 8'd0;
    endfunction

    // appends one expected result at the tail of the queue
    function automatic void queue_result(input parse_result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // one request through the model, returns the result it must produce
    function automatic parse_result_t parse_step(input logic cmd, input logic [7:0] b);
        parse_result_t r;
        logic [16:0]   next_idle;
        logic [8:0]    frame_end;
        logic          reject;
        logic          done;
        r = '0;
        reject = 1'b0;
        done = 1'b0;
        if (cmd == CMD_TICK)
        begin
            next_idle = {1'b0, idle_ticks} + 17'd1;
            if (next_idle > {1'b0, gap_cfg})
            begin
                // gap expired: partial frame is thrown away
                drop_frame();
                idle_ticks = 16'd0;
                r.status = ST_REJECT;
            end
            else
            begin
                idle_ticks = next_idle[15:0];
            end
            r.ftype = type_seen;
            r.flen = len_seen;
        end
        else
        begin
            frame_end = PosPayload + {1'b0, len_seen};
            if (frame_pos < PosVersion)
            begin
                reject = (b != header_at(int'(frame_pos)));
            end
            else if (frame_pos == PosVersion)
            begin
                reject = (b != version_cfg);
            end
            else if (frame_pos == PosType)
            begin
                type_seen = b;
            end
            else if (frame_pos == PosLength)
            begin
                len_seen = b;
                frame_end = PosPayload + {1'b0, b};
            end
            else if (frame_pos < frame_end)
            begin
                r.pvalid = 1'b1;
                r.pbyte = b;
            end
            else
            begin
                // checksum byte closes the frame
                done = 1'b1;
                r.last = 1'b1;
                if (b != byte_sum)
                    r.status = ST_SUM_ERR;
                else if (type_seen == rpc_cfg)
                    r.status = ST_RPC_OK;
                else
                    r.status = ST_FRAME_OK;
            end
            r.ftype = type_seen;
            r.flen = len_seen;
            if (reject)
            begin
                // idle count survives a reject
                r.status = ST_REJECT;
                drop_frame();
            end
            else if (done)
            begin
                if (r.status != ST_SUM_ERR)
                    idle_ticks = 16'd0;
                drop_frame();
            end
            else
            begin
                byte_sum = byte_sum + b;
                frame_pos = frame_pos + 9'd1;
                idle_ticks = 16'd0;
            end
        end
        return r;
    endfunction

    function automatic int unsigned draw_wait();
        return back_to_back ? 0 : $urandom_range(0, 18);
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // sends one request, queues its expected result once accepted
    task automatic send_request(input logic cmd, input logic [7:0] b);
        int unsigned hold;
        hold = draw_wait();
        repeat (hold)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        command <= cmd;
        data_byte <= b;
        // in_stall sampled before the edge updates it
        do
            @(posedge clk);
        while (in_stall);
        queue_result(parse_step(cmd, b));
        requests_sent++;
        if (cmd == CMD_TICK)
            ticks_sent++;
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count)
            send_request(CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    // frame byte, optionally preceded by a short burst of ticks
    task automatic frame_byte(input logic [7:0] b, input bit with_ticks,
                              inout logic [7:0] sum);
        if (with_ticks && $urandom_range(0, 19) == 0)
            send_ticks($urandom_range(1, 2));
        send_request(CMD_BYTE, b);
        sum = sum + b;
    endtask

    // complete frame with random payload; bad_sum corrupts the checksum byte
    task automatic send_frame(input logic [7:0] ver, input logic [7:0] ftype,
                              input logic [7:0] flen, input bit bad_sum,
                              input bit with_ticks);
        logic [7:0] sum;
        sum = 8'd0;
        for (int i = 0; i < HeaderLen; i++)
            frame_byte(header_at(i), with_ticks, sum);
        frame_byte(ver, with_ticks, sum);
        frame_byte(ftype, with_ticks, sum);
        frame_byte(flen, with_ticks, sum);
        for (int i = 0; i < int'(flen); i++)
            frame_byte(8'($urandom_range(0, 255)), with_ticks, sum);
        if (bad_sum)
            sum = sum + 8'($urandom_range(1, 255));
        if (with_ticks && $urandom_range(0, 19) == 0)
            send_ticks(1);
        send_request(CMD_BYTE, sum);
    endtask

    // drop valid and wait until every queued result has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // two-stage pipe, so wait on past the last result
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [1:0] idx, input logic [15:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_VERSION: version_cfg = value[7:0];
            CFG_RPC:     rpc_cfg = value[7:0];
            CFG_GAP:     gap_cfg = value;
            default:     ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall per result, checked at the rising edge
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            hold = draw_wait();
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic report_field(input string name, input int unsigned want,
                                input logic [7:0] got, input logic got_x);
        if (got_x || got != 8'(want))
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual status %0d",
                         $time, status);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                report_field("status", want.status, {5'd0, status}, $isunknown(status));
                report_field("payload_valid", want.pvalid, {7'd0, payload_valid},
                             $isunknown(payload_valid));
                report_field("payload_byte", want.pbyte, payload_byte,
                             $isunknown(payload_byte));
                report_field("frame_type", want.ftype, frame_type, $isunknown(frame_type));
                report_field("frame_len", want.flen, frame_len, $isunknown(frame_len));
                report_field("last", want.last, {7'd0, frame_last}, $isunknown(frame_last));
                case (want.status)
                    ST_RPC_OK, ST_FRAME_OK: good_frames++;
                    ST_SUM_ERR:             sum_errors++;
                    ST_REJECT:              rejects++;
                    default:                ;
                endcase
                if (want.pvalid)
                    payload_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset config: rpc frame, non-rpc frames, empty payload, extreme bytes
    task automatic test_good_frames();
        send_frame(VersionReset, RpcReset, 8'd2, 1'b0, 1'b0);
        send_frame(VersionReset, 8'hFF, 8'd0, 1'b0, 1'b0);
        send_request(CMD_BYTE, 8'h00);
        send_frame(VersionReset, 8'h00, 8'd1, 1'b0, 1'b0);
    endtask

    // wrong byte at every header position and at the version byte
    task automatic test_header_reject();
        for (int p = 0; p <= HeaderLen; p++)
        begin
            for (int i = 0; i < p; i++)
                send_request(CMD_BYTE, header_at(i));
            if (p == HeaderLen)
                send_request(CMD_BYTE, version_cfg ^ 8'h80);
            else
                send_request(CMD_BYTE, header_at(p) ^ 8'h01);
        end
        // the byte that rejects is not taken as a new start
        send_request(CMD_BYTE, header_at(0));
        send_request(CMD_BYTE, header_at(1));
        send_request(CMD_BYTE, header_at(0));
        send_request(CMD_BYTE, header_at(1));
    endtask

    // bad checksum, then a good frame straight after
    task automatic test_checksum_error();
        send_frame(VersionReset, 8'h41, 8'd3, 1'b1, 1'b0);
        send_frame(VersionReset, RpcReset, 8'd1, 1'b0, 1'b0);
    endtask

    // idle gap at small, zero and largest settings
    task automatic test_idle_gap();
        write_config(CFG_GAP, 16'd3);
        send_ticks(5);
        for (int i = 0; i < 8; i++)
            send_request(CMD_BYTE, i < HeaderLen ? header_at(i) : RpcReset);
        send_ticks(4);
        send_frame(VersionReset, RpcReset, 8'd1, 1'b0, 1'b1);
        write_config(CFG_GAP, 16'd0);
        send_ticks(3);
        send_request(CMD_BYTE, header_at(0));
        send_ticks(1);
        write_config(CFG_GAP, 16'hFFFF);
        send_ticks(20);
        send_frame(VersionReset, 8'h10, 8'd2, 1'b0, 1'b1);
    endtask

    // version and rpc type at both ends, masked data, ignored index
    task automatic test_config_regs();
        write_config(CFG_VERSION, 16'hAB00);
        write_config(CFG_RPC, 16'h00FF);
        send_frame(8'h00, 8'hFF, 8'd1, 1'b0, 1'b0);
        write_config(CFG_VERSION, 16'h00FF);
        write_config(CFG_RPC, 16'hFF00);
        send_frame(8'hFF, 8'h00, 8'd0, 1'b0, 1'b0);
        send_frame(8'h00, 8'h00, 8'd0, 1'b0, 1'b0);
        write_config(CFG_UNUSED, 16'hFFFF);
        send_frame(8'hFF, 8'hFF, 8'd0, 1'b0, 1'b0);
    endtask

    // mostly well-formed frames, plus broken frames, noise and tick runs
    task automatic test_random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned cut;
        int unsigned flen;
        logic [7:0]  ftype;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
        begin
            if ($urandom_range(0, 14) == 0)
                back_to_back = ~back_to_back;
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                ftype = ($urandom_range(0, 2) == 0) ? rpc_cfg : 8'($urandom_range(0, 255));
                case ($urandom_range(0, 29))
                    0:       flen = $urandom_range(200, 255);
                    1, 2, 3: flen = 0;
                    default: flen = $urandom_range(1, 12);
                endcase
                send_frame(version_cfg, ftype, 8'(flen), $urandom_range(0, 6) == 0,
                           $urandom_range(0, 3) == 0);
            end
            else if (pick < 80)
            begin
                // frame cut short by a wrong byte or by an idle gap; left partial if the gap is 64 or more
                cut = $urandom_range(0, 8);
                for (int i = 0; i < int'(cut); i++)
                begin
                    if (i < HeaderLen)
                        send_request(CMD_BYTE, header_at(i));
                    else if (i == HeaderLen)
                        send_request(CMD_BYTE, version_cfg);
                    else
                        send_request(CMD_BYTE, 8'($urandom_range(0, 255)));
                end
                if (cut < HeaderLen)
                    send_request(CMD_BYTE, header_at(cut) ^ 8'(1 << $urandom_range(0, 7)));
                else if (cut == HeaderLen)
                    send_request(CMD_BYTE, version_cfg ^ 8'(1 << $urandom_range(0, 7)));
                else if (gap_cfg < 16'd64)
                    send_ticks(gap_cfg + 1);
            end
            else if (pick < 88)
            begin
                repeat ($urandom_range(1, 6))
                    send_request($urandom_range(0, 9) == 0 ? CMD_TICK : CMD_BYTE,
                                 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_ticks($urandom_range(1, gap_cfg > 60 ? 8 : int'(gap_cfg) + 2));
            end
        end
        back_to_back = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_good_frames();
        test_header_reject();
        test_checksum_error();
        test_idle_gap();
        test_config_regs();

        // random phases over several config settings
        write_config(CFG_VERSION, 16'd1);
        write_config(CFG_RPC, 16'd3);
        write_config(CFG_GAP, 16'd50);
        test_random_traffic(400);
        write_config(CFG_VERSION, 16'd0);
        write_config(CFG_RPC, 16'd255);
        write_config(CFG_GAP, 16'd1);
        test_random_traffic(400);
        write_config(CFG_VERSION, 16'd255);
        write_config(CFG_RPC, 16'd0);
        write_config(CFG_GAP, 16'hFFFF);
        test_random_traffic(400);
        write_config(CFG_VERSION, 16'($urandom_range(0, 255)));
        write_config(CFG_RPC, 16'($urandom_range(0, 255)));
        write_config(CFG_GAP, 16'd5);
        test_random_traffic(400);
        write_config(CFG_GAP, 16'd0);
        test_random_traffic(400);

        wait_idle();
        $display("run covered %0d requests (%0d ticks), %0d results checked",
                 requests_sent, ticks_sent, results_checked);
        $display("good frames %0d, checksum errors %0d, rejects %0d, payload bytes %0d",
                 good_frames, sum_errors, rejects, payload_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #20ms;
        $display("%0t: timeout with %0d results outstanding", $time,
                 expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
